>>> sv/udom83_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udom83 package
// shared types, constants and lookup functions of the phonetic coder
// ----------------------------------------------------------------------------
package udom83_pkg;

   localparam int MaxChars = 255;
   localparam int CodeLen  = 7;
   localparam int DigLen   = CodeLen - 1;
   localparam int TakenW   = $clog2(MaxChars + 1);
   localparam int DcntW    = $clog2(DigLen + 1);
   localparam int OutW     = $clog2(CodeLen);

   localparam logic [15:0] CpThanthakhat = 16'h0E4C;
   localparam logic [15:0] CpMaiHanAkat  = 16'h0E31;
   localparam logic [15:0] CpNoNu        = 16'h0E19;
   localparam logic [15:0] CpYoYak       = 16'h0E22;
   localparam logic [15:0] CpMoMa        = 16'h0E21;
   localparam logic [15:0] CpSaraAm      = 16'h0E33;
   localparam logic [15:0] CpRoRua       = 16'h0E23;
   localparam logic [15:0] CpSaraA       = 16'h0E30;
   localparam logic [15:0] CpSaraAi      = 16'h0E44;
   localparam logic [15:0] CpSaraAiM     = 16'h0E43;
   localparam logic [15:0] CpSaraE       = 16'h0E40;
   localparam logic [15:0] CpConsLo      = 16'h0E01;
   localparam logic [15:0] CpConsHi      = 16'h0E2E;
   localparam logic [15:0] CpVowelHi     = 16'h0E39;
   localparam logic [15:0] CpAsciiZero   = 16'h0030;
   localparam logic [3:0]  NoDigit       = 4'hF;

   typedef struct packed {
      logic [15:0] codepoint;
      logic        end_of_word;
   } req_type;

   typedef struct packed {
      logic [15:0] code_char;
      logic        empty_code;
      logic        last_char;
   } rsp_type;

   function automatic logic is_cons(input logic [15:0] c);
      return (c >= CpConsLo) && (c <= CpConsHi);
   endfunction

   function automatic logic [15:0] lead_map(input logic [15:0] c);
      logic [15:0] r;
      r = c;
      case (c)
         16'h0E03, 16'h0E04, 16'h0E05, 16'h0E06: r = 16'h0E02;
         16'h0E09, 16'h0E0C: r = 16'h0E0A;
         16'h0E0B, 16'h0E28, 16'h0E29: r = 16'h0E2A;
         16'h0E0E: r = 16'h0E14;
         16'h0E0F: r = 16'h0E15;
         16'h0E10, 16'h0E11, 16'h0E12, 16'h0E16, 16'h0E18: r = 16'h0E17;
         16'h0E13: r = 16'h0E19;
         16'h0E1C, 16'h0E20: r = 16'h0E1E;
         16'h0E1D: r = 16'h0E1F;
         16'h0E0D: r = 16'h0E22;
         16'h0E25, 16'h0E2C, 16'h0E24, 16'h0E26: r = 16'h0E23;
         16'h0E2E: r = 16'h0E2B;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] digit_map(input logic [15:0] c);
      logic [3:0] d;
      case (c)
         16'h0E21, 16'h0E27, 16'h0E33: d = 4'd0;
         16'h0E01, 16'h0E02, 16'h0E03, 16'h0E04, 16'h0E05, 16'h0E06: d = 4'd1;
         16'h0E07: d = 4'd2;
         16'h0E22, 16'h0E0D, 16'h0E13, 16'h0E19: d = 4'd3;
         16'h0E0E, 16'h0E0F, 16'h0E14, 16'h0E15,
         16'h0E28, 16'h0E29, 16'h0E2A: d = 4'd4;
         16'h0E1A, 16'h0E1B, 16'h0E1E, 16'h0E20: d = 4'd5;
         16'h0E1C, 16'h0E1D, 16'h0E1F, 16'h0E2B, 16'h0E2D, 16'h0E2E: d = 4'd6;
         16'h0E08, 16'h0E09, 16'h0E0A, 16'h0E0B, 16'h0E0C: d = 4'd7;
         16'h0E10, 16'h0E11, 16'h0E12, 16'h0E16, 16'h0E17, 16'h0E18: d = 4'd8;
         16'h0E23, 16'h0E24, 16'h0E25, 16'h0E26: d = 4'd9;
         default: d = NoDigit;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

>>> sv/thai_udom83_phonetic_code.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udom83 phonetic coder, top level
// rewrite sequencer feeding a shared cleaning step, then code emission
// ----------------------------------------------------------------------------
// a character takes a rewrite step, then one cleaning step per
// codepoint handed on; the rewrite window is worked once four are held
// or at end of word; end of word flushes both windows, then emits 1 or 7
// result beats, one per cycle as taken; req_ready is low throughout
// synchronous reset clears all control state; digit store is not cleared
module thai_udom83_phonetic_code (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire udom83_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output udom83_pkg::rsp_type       rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RW   = 4'b0010,
      ST_CL   = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type   st_ff, st_in;
   logic [15:0] rw_ff [4];
   logic [15:0] rw_in [4];
   logic [2:0]  rfill_ff, rfill_in;
   logic        last_ff, last_in;
   logic [udom83_pkg::TakenW-1:0] taken_ff, taken_in;
   logic [15:0] q_ff [2];
   logic [15:0] q_in [2];
   logic [1:0]  qn_ff, qn_in;
   logic [udom83_pkg::OutW-1:0] k_ff, k_in;
   logic [2:0]  drop;
   logic [15:0] e0, e1;
   logic [1:0]  en;
   logic        c_push, c_step, c_clear;
   logic [1:0]  c_fill;
   logic [15:0] c_lead;
   logic        c_hl;
   logic [udom83_pkg::DcntW-1:0] c_dc;
   logic [3:0]  c_dig [udom83_pkg::DigLen];
   logic [15:0] a, b, c, d;
   logic [udom83_pkg::DcntW-1:0] kd;

   udom83_clean u_clean (
      .clock, .reset,
      .push(c_push), .push_cp(q_ff[0]), .step(c_step), .clear(c_clear),
      .fill(c_fill), .lead(c_lead), .have_lead(c_hl), .dcount(c_dc), .dig(c_dig)
   );

   assign a = rw_ff[0];
   assign b = rw_ff[1];
   assign c = rw_ff[2];
   assign d = rw_ff[3];

   // rewrite rule on the current window
   always_comb begin
      e0 = a; e1 = '0; en = 2'd1; drop = 3'd1;
      if (rfill_ff >= 3'd2 && a == udom83_pkg::CpRoRua && b == udom83_pkg::CpRoRua) begin
         e0 = udom83_pkg::CpMaiHanAkat; e1 = udom83_pkg::CpNoNu; drop = 3'd2;
         en = (rfill_ff >= 3'd4 && udom83_pkg::is_cons(c) && (udom83_pkg::is_cons(d) ||
              (d >= udom83_pkg::CpSaraE && d <= udom83_pkg::CpSaraAi))) ? 2'd1 : 2'd2;
      end else if (a == udom83_pkg::CpSaraAi && rfill_ff >= 3'd3 &&
                   udom83_pkg::is_cons(b) && c == udom83_pkg::CpYoYak) begin
         e0 = b; e1 = udom83_pkg::CpYoYak; en = 2'd2; drop = 3'd3;
      end else if ((a == udom83_pkg::CpSaraAi || a == udom83_pkg::CpSaraAiM) &&
                   rfill_ff >= 3'd2 && udom83_pkg::is_cons(b)) begin
         e0 = b; e1 = udom83_pkg::CpYoYak; en = 2'd2; drop = 3'd2;
      end else if (a == udom83_pkg::CpSaraAm) begin
         e0 = udom83_pkg::CpMoMa;
         if (rfill_ff >= 3'd3 && b == udom83_pkg::CpMoMa &&
             c >= udom83_pkg::CpSaraA && c <= udom83_pkg::CpVowelHi) drop = 3'd1;
         else if (rfill_ff >= 3'd2 && b == udom83_pkg::CpMoMa) drop = 3'd2;
      end
   end

   assign kd = udom83_pkg::DcntW'(k_ff - 1'b1);

   always_comb begin
      st_in = st_ff; rw_in = rw_ff; rfill_in = rfill_ff; last_in = last_ff;
      taken_in = taken_ff; q_in = q_ff; qn_in = qn_ff; k_in = k_ff;
      c_push = 1'b0; c_step = 1'b0; c_clear = 1'b0;
      req_ready = 1'b0; rsp_valid = 1'b0;
      rsp_data = '0;
      case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in = req_data.end_of_word;
               if (taken_ff < udom83_pkg::TakenW'(udom83_pkg::MaxChars)) begin
                  taken_in = taken_ff + 1'b1;
                  rw_in[rfill_ff[1:0]] = req_data.codepoint;
                  rfill_in = rfill_ff + 3'd1;
               end
               st_in = ST_RW;
            end
         end
         ST_RW: begin
            if (rfill_ff == 3'd4 || (last_ff && rfill_ff != 3'd0)) begin
               q_in[0] = e0; q_in[1] = e1; qn_in = en;
               case (drop)
                  3'd3: begin rw_in[0] = d; end
                  3'd2: begin rw_in[0] = c; rw_in[1] = d; end
                  default: begin rw_in[0] = b; rw_in[1] = c; rw_in[2] = d; end
               endcase
               rfill_in = rfill_ff - drop;
               st_in = ST_CL;
            end else if (last_ff && c_fill != 2'd0) begin
               c_step = 1'b1;
            end else if (last_ff) begin
               k_in = '0;
               st_in = ST_OUT;
            end else begin
               st_in = ST_IDLE;
            end
         end
         ST_CL: begin
            if (c_fill == 2'd3) begin
               c_step = 1'b1;
            end else if (qn_ff != 2'd0) begin
               c_push = 1'b1;
               q_in[0] = q_ff[1];
               qn_in = qn_ff - 2'd1;
            end else begin
               st_in = ST_RW;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!c_hl) begin
               rsp_data.empty_code = 1'b1;
               rsp_data.last_char  = 1'b1;
            end else begin
               rsp_data.last_char = (k_ff == udom83_pkg::OutW'(udom83_pkg::CodeLen - 1));
               if (k_ff == '0) rsp_data.code_char = c_lead;
               else if (kd < c_dc)
                  rsp_data.code_char = udom83_pkg::CpAsciiZero + 16'(c_dig[kd]);
               else rsp_data.code_char = udom83_pkg::CpAsciiZero;
            end
            if (rsp_ready) begin
               k_in = k_ff + 1'b1;
               if (rsp_data.last_char) begin
                  c_clear = 1'b1; rfill_in = '0; taken_in = '0; last_in = 1'b0;
                  st_in = ST_IDLE;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rfill_ff <= '0; last_ff <= 1'b0; taken_ff <= '0;
         qn_ff <= '0; k_ff <= '0;
      end else begin
         st_ff <= st_in; rfill_ff <= rfill_in; last_ff <= last_in; taken_ff <= taken_in;
         qn_ff <= qn_in; k_ff <= k_in;
      end
      rw_ff <= rw_in;
      q_ff  <= q_in;
   end

endmodule
`default_nettype wire

>>> sv/udom83_clean.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udom83 cleaning and encoding stage
// three-entry lookahead; drops karant clusters and marks, maps survivors
// ----------------------------------------------------------------------------
module udom83_clean (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic [15:0] push_cp,
   input  wire logic        step,
   input  wire logic        clear,
   output logic [1:0]       fill,
   output logic [15:0]      lead,
   output logic             have_lead,
   output logic [udom83_pkg::DcntW-1:0] dcount,
   output logic [3:0]       dig [udom83_pkg::DigLen]
);

   logic [15:0] win_ff [3];
   logic [15:0] win_in [3];
   logic [1:0]  fill_ff, fill_in;
   logic [15:0] lead_ff, lead_in;
   logic        hl_ff, hl_in;
   logic [udom83_pkg::DcntW-1:0] dc_ff, dc_in;
   logic [3:0]  dig_ff [udom83_pkg::DigLen];
   logic        dwe;
   logic [3:0]  dval;
   logic [1:0]  drop;
   logic        enc;
   logic [15:0] a, b;
   logic [3:0]  dm;

   assign a  = win_ff[0];
   assign b  = win_ff[1];
   assign dm = udom83_pkg::digit_map(a);

   // one drop step of the lookahead when step is high
   always_comb begin
      drop = 2'd1;
      enc  = 1'b0;
      if (fill_ff == 2'd3 && win_ff[2] == udom83_pkg::CpThanthakhat &&
          ((a == 16'h0E08 && b == 16'h0E19) || (a == 16'h0E21 && b == 16'h0E13) ||
           (a == 16'h0E13 && b == 16'h0E11) || (a == 16'h0E17 && b == 16'h0E23) ||
           (a == 16'h0E15 && b == 16'h0E23) ||
           (udom83_pkg::is_cons(a) && b >= udom83_pkg::CpSaraA &&
            b <= udom83_pkg::CpVowelHi))) begin
         drop = 2'd3;
      end else if (fill_ff >= 2'd2 && b == udom83_pkg::CpThanthakhat &&
                   udom83_pkg::is_cons(a)) begin
         drop = 2'd2;
      end else begin
         enc = !(a >= udom83_pkg::CpSaraA && a <= udom83_pkg::CpThanthakhat);
      end
   end

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      lead_in = lead_ff;
      hl_in   = hl_ff;
      dc_in   = dc_ff;
      dwe     = 1'b0;
      dval    = dm;
      if (clear) begin
         fill_in = '0;
         hl_in   = 1'b0;
         lead_in = '0;
         dc_in   = '0;
      end else if (step) begin
         case (drop)
            2'd3: begin
               fill_in = '0;
            end
            2'd2: begin
               win_in[0] = win_ff[2];
               fill_in   = fill_ff - 2'd2;
            end
            default: begin
               win_in[0] = win_ff[1];
               win_in[1] = win_ff[2];
               fill_in   = fill_ff - 2'd1;
            end
         endcase
         if (enc) begin
            if (!hl_ff) begin
               lead_in = udom83_pkg::lead_map(a);
               hl_in   = 1'b1;
            end else if (dm != udom83_pkg::NoDigit &&
                         dc_ff < udom83_pkg::DcntW'(udom83_pkg::DigLen)) begin
               dwe   = 1'b1;
               dc_in = dc_ff + 1'b1;
            end
         end
      end else if (push) begin
         win_in[fill_ff] = push_cp;
         fill_in         = fill_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         hl_ff   <= 1'b0;
         lead_ff <= '0;
         dc_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         hl_ff   <= hl_in;
         lead_ff <= lead_in;
         dc_ff   <= dc_in;
      end
      win_ff <= win_in;
      if (dwe) begin
         dig_ff[dc_ff[udom83_pkg::DcntW-1:0]] <= dval;
      end
   end

   assign fill      = fill_ff;
   assign lead      = lead_ff;
   assign have_lead = hl_ff;
   assign dcount    = dc_ff;
   assign dig       = dig_ff;

endmodule
`default_nettype wire

>>> sv/udom83_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udom83 port checker
// watches handshakes of the top level and is bound to it
// ----------------------------------------------------------------------------
module udom83_check (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire udom83_pkg::rsp_type rsp_data
);

   // never takes a request while a result beat is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready)) else $error("ready during output");

   // stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // empty code is single and final
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_code |-> rsp_data.last_char && rsp_data.code_char == 16'h0)
      else $error("bad empty beat");

   // after final beat taken, ready for the next word
   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_char |=> req_ready && !rsp_valid)
      else $error("not back to idle");

endmodule

bind thai_udom83_phonetic_code udom83_check u_check (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire
